>>> rtl/bfl_pkg.sv
package bfl_pkg;

  localparam int FRAMES       = 8;
  localparam int FILE_ID_BITS = 8;
  localparam int OFFSET_BITS  = 20;
  localparam int STAMP_BITS   = 32;
  localparam int FRAME_BITS   = $clog2(FRAMES);
  localparam int FRAME_W      = 3;
  localparam int OP_W         = 2;
  localparam int STATUS_W     = 2;

  typedef enum logic [OP_W-1:0] {
    OP_LOOKUP = 2'd0,
    OP_DIRTY  = 2'd1,
    OP_PIN    = 2'd2,
    OP_DROP   = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_HIT  = 2'd0,
    STS_MISS = 2'd1,
    STS_FULL = 2'd2,
    STS_DONE = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    UPD_NONE,
    UPD_STAMP,
    UPD_FILL,
    UPD_DIRTY,
    UPD_PIN,
    UPD_DROP
  } upd_kind_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SWEEP,
    S_FINISH
  } fsm_t;

  // Search token handed from one frame to the next along the chain.
  typedef struct packed {
    logic                    hit_found;
    logic [FRAME_BITS-1:0]   hit_idx;
    logic                    free_found;
    logic [FRAME_BITS-1:0]   free_idx;
    logic                    lru_found;
    logic [FRAME_BITS-1:0]   lru_idx;
    logic [STAMP_BITS-1:0]   lru_stamp;
    logic                    lru_dirty;
    logic [FILE_ID_BITS-1:0] lru_file;
    logic [OFFSET_BITS-1:0]  lru_block;
  } carry_t;

  // Update broadcast to every frame at the end of a request.
  typedef struct packed {
    upd_kind_t               kind;
    logic [FRAME_BITS-1:0]   idx;
    logic [FILE_ID_BITS-1:0] file;
    logic [OFFSET_BITS-1:0]  block;
    logic [STAMP_BITS-1:0]   stamp;
  } upd_t;

endpackage

>>> rtl/bfl_cell.sv
module bfl_cell
  import bfl_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic [FRAME_BITS-1:0]   idx,
  input  logic [FILE_ID_BITS-1:0] req_file,
  input  logic [OFFSET_BITS-1:0]  req_block,
  input  carry_t                  carry_in,
  output carry_t                  carry_out,
  input  upd_t                    upd
);

  logic                    valid;
  logic                    dirty;
  logic                    pinned;
  logic [FILE_ID_BITS-1:0] file;
  logic [OFFSET_BITS-1:0]  block;
  logic [STAMP_BITS-1:0]   stamp;
  carry_t                  carry_next;
  logic                    targeted;
  logic                    drop_hit;

  assign targeted = (upd.idx == idx);
  assign drop_hit = valid && (file == upd.file);

  always_comb begin
    carry_next = carry_in;
    if (!carry_in.hit_found && valid && file == req_file && block == req_block) begin
      carry_next.hit_found = 1'b1;
      carry_next.hit_idx   = idx;
    end
    if (!carry_in.free_found && !valid) begin
      carry_next.free_found = 1'b1;
      carry_next.free_idx   = idx;
    end
    // Strictly older only, so the lower index keeps a tie.
    if (!pinned && (!carry_in.lru_found || stamp < carry_in.lru_stamp)) begin
      carry_next.lru_found = 1'b1;
      carry_next.lru_idx   = idx;
      carry_next.lru_stamp = stamp;
      carry_next.lru_dirty = dirty;
      carry_next.lru_file  = file;
      carry_next.lru_block = block;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      carry_out <= '0;
    end else begin
      carry_out <= carry_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= 1'b0;
      dirty  <= 1'b0;
      pinned <= 1'b0;
    end else begin
      case (upd.kind)
        UPD_FILL: begin
          if (targeted) begin
            valid  <= 1'b1;
            dirty  <= 1'b0;
            pinned <= 1'b0;
          end
        end
        UPD_DIRTY: begin
          if (targeted) dirty <= 1'b1;
        end
        UPD_PIN: begin
          if (targeted) pinned <= 1'b1;
        end
        UPD_DROP: begin
          if (drop_hit) begin
            valid  <= 1'b0;
            dirty  <= 1'b0;
            pinned <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      file  <= '0;
      block <= '0;
      stamp <= '0;
    end else begin
      if (targeted && upd.kind == UPD_FILL) begin
        file  <= upd.file;
        block <= upd.block;
      end
      if (targeted && (upd.kind == UPD_FILL || upd.kind == UPD_STAMP)) begin
        stamp <= upd.stamp;
      end
    end
  end

endmodule

>>> rtl/buffer_frame_lru_directory.sv
// Buffer-pool frame directory with least-recently-used replacement.
// Requests arrive on the input channel (in_valid / in_stall): a lookup by
// file_id and block_offset, a dirty or pin mark on a frame, or a drop of
// every frame of a file. Each request gives exactly one result on the
// output channel (out_valid / out_stall): the frame, a status and, for an
// evicted dirty frame, the tag that must be written back.
// A lookup is searched by a token that walks the row of frame slots, one
// slot per cycle; once the token has left the last slot, the result is
// loaded into the output register when the output is free. Mark and drop
// requests skip the walk and are answered when the output is free.
// One request is in flight at a time; a new request is taken as soon as the
// previous result sits in the output register, even if it is still waiting.
// While the receiver stalls, the result register holds its value and a
// finished request waits before it updates the directory.
// Reset empties the directory and clears the access counter; the block is
// ready for a request as soon as reset is released.
module buffer_frame_lru_directory
  import bfl_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [OP_W-1:0]         operation,
  input  logic [FILE_ID_BITS-1:0] file_id,
  input  logic [OFFSET_BITS-1:0]  block_offset,
  input  logic [FRAME_W-1:0]      frame,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [FRAME_W-1:0]      frame_out,
  output logic [STATUS_W-1:0]     status,
  output logic                    writeback_valid,
  output logic [FILE_ID_BITS-1:0] writeback_file_id,
  output logic [OFFSET_BITS-1:0]  writeback_offset
);

  fsm_t                    state;
  fsm_t                    state_next;
  logic [FRAME_BITS-1:0]   count;
  logic                    sweep_last;
  op_t                     req_op;
  logic [FILE_ID_BITS-1:0] req_file;
  logic [OFFSET_BITS-1:0]  req_block;
  logic [FRAME_W-1:0]      req_frame;
  logic [STAMP_BITS-1:0]   access_clock;
  logic [STAMP_BITS-1:0]   stamp_inc;
  logic                    clock_adv;
  logic                    out_free;
  logic                    out_load;
  logic                    in_xfer;
  carry_t                  chain [FRAMES];
  carry_t                  tail;
  upd_t                    upd_raw;
  upd_t                    upd;
  logic [FRAME_BITS-1:0]   res_idx;
  status_t                 res_status;
  logic                    res_wb;
  logic [FILE_ID_BITS-1:0] res_wb_file;
  logic [OFFSET_BITS-1:0]  res_wb_block;
  logic                    frame_in_range;

  assign in_stall   = (state != S_IDLE);
  assign in_xfer    = in_valid && !in_stall;
  assign out_free   = !out_valid || !out_stall;
  assign sweep_last = (count == FRAME_BITS'(FRAMES - 1));
  assign tail       = chain[FRAMES-1];
  assign stamp_inc  = access_clock + STAMP_BITS'(1);
  assign frame_in_range = (32'(req_frame) < 32'(FRAMES));

  for (genvar i = 0; i < FRAMES; i++) begin : g_frame
    carry_t carry_in;
    if (i == 0) begin : g_head
      assign carry_in = '0;
    end else begin : g_link
      assign carry_in = chain[i-1];
    end
    bfl_cell u_frame (
      .clk       (clk),
      .rst       (rst),
      .idx       (FRAME_BITS'(i)),
      .req_file  (req_file),
      .req_block (req_block),
      .carry_in  (carry_in),
      .carry_out (chain[i]),
      .upd       (upd)
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    out_load   = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_xfer) begin
          state_next = (op_t'(operation) == OP_LOOKUP) ? S_SWEEP : S_FINISH;
        end
      end
      S_SWEEP: begin
        if (sweep_last) state_next = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (state == S_SWEEP) begin
      count <= count + FRAME_BITS'(1);
    end else begin
      count <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      req_op    <= op_t'(operation);
      req_file  <= file_id;
      req_block <= block_offset;
      req_frame <= frame;
    end
  end

  // Decide the outcome from the token at the end of the chain.
  always_comb begin
    upd_raw       = '0;
    upd_raw.kind  = UPD_NONE;
    upd_raw.file  = req_file;
    upd_raw.block = req_block;
    upd_raw.stamp = stamp_inc;
    res_idx       = '0;
    res_status    = STS_DONE;
    res_wb        = 1'b0;
    res_wb_file   = '0;
    res_wb_block  = '0;
    clock_adv     = 1'b0;
    case (req_op)
      OP_LOOKUP: begin
        if (tail.hit_found) begin
          upd_raw.kind = UPD_STAMP;
          upd_raw.idx  = tail.hit_idx;
          res_idx      = tail.hit_idx;
          res_status   = STS_HIT;
          clock_adv    = 1'b1;
        end else if (tail.free_found) begin
          upd_raw.kind = UPD_FILL;
          upd_raw.idx  = tail.free_idx;
          res_idx      = tail.free_idx;
          res_status   = STS_MISS;
          clock_adv    = 1'b1;
        end else if (tail.lru_found) begin
          upd_raw.kind = UPD_FILL;
          upd_raw.idx  = tail.lru_idx;
          res_idx      = tail.lru_idx;
          res_status   = STS_MISS;
          clock_adv    = 1'b1;
          if (tail.lru_dirty) begin
            res_wb       = 1'b1;
            res_wb_file  = tail.lru_file;
            res_wb_block = tail.lru_block;
          end
        end else begin
          res_status = STS_FULL;
        end
      end
      OP_DIRTY: begin
        if (frame_in_range) begin
          upd_raw.kind = UPD_DIRTY;
          upd_raw.idx  = FRAME_BITS'(req_frame);
        end
      end
      OP_PIN: begin
        if (frame_in_range) begin
          upd_raw.kind = UPD_PIN;
          upd_raw.idx  = FRAME_BITS'(req_frame);
        end
      end
      OP_DROP: begin
        upd_raw.kind = UPD_DROP;
      end
      default: ;
    endcase
  end

  always_comb begin
    upd = upd_raw;
    if (!out_load) upd.kind = UPD_NONE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      access_clock <= '0;
    end else if (out_load && clock_adv) begin
      access_clock <= stamp_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      frame_out         <= FRAME_W'(res_idx);
      status            <= res_status;
      writeback_valid   <= res_wb;
      writeback_file_id <= res_wb_file;
      writeback_offset  <= res_wb_block;
    end
  end

`ifndef SYNTHESIS
  a_wb_only_on_miss: assert property (@(posedge clk) disable iff (rst)
    out_valid && writeback_valid |-> status == STS_MISS)
    else $error("write-back reported without a miss fill");

  a_full_frame_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == STS_FULL || status == STS_DONE) |-> frame_out == '0)
    else $error("frame_out not zero for a result that names no frame");

  a_clock_step: assert property (@(posedge clk) disable iff (rst)
    out_load && (res_status == STS_HIT || res_status == STS_MISS)
    |=> access_clock == $past(stamp_inc))
    else $error("access counter did not advance on a hit or fill");

  a_sweep_then_finish: assert property (@(posedge clk) disable iff (rst)
    state == S_SWEEP && sweep_last |=> state == S_FINISH)
    else $error("lookup sweep did not end in the finish step");
`endif

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps

module tb;
  import bfl_pkg::*;

  localparam int TOTAL_REQUESTS = 1550;
  localparam int QUIET_TAIL     = 150;
  localparam int LONG_HOLD      = 300;
  localparam int TAG_POOL       = 12;
  localparam int SETTLE_CYCLES  = 2 * (FRAMES + 2);

  typedef struct {
    op_t                     op;
    logic [FILE_ID_BITS-1:0] fid;
    logic [OFFSET_BITS-1:0]  off;
    logic [FRAME_W-1:0]      fr;
  } request_t;

  typedef struct {
    logic [FRAME_W-1:0]      frame;
    status_t                 status;
    logic                    wb_valid;
    logic [FILE_ID_BITS-1:0] wb_file;
    logic [OFFSET_BITS-1:0]  wb_off;
  } reply_t;

  typedef struct {
    request_t req;
    bit       typed;
    reply_t   want;
  } directed_row_t;

  logic                    clk;
  logic                    rst;
  logic                    in_valid;
  logic                    in_stall;
  logic [OP_W-1:0]         operation;
  logic [FILE_ID_BITS-1:0] file_id;
  logic [OFFSET_BITS-1:0]  block_offset;
  logic [FRAME_W-1:0]      frame;
  logic                    out_valid;
  logic                    out_stall;
  logic [FRAME_W-1:0]      frame_out;
  logic [STATUS_W-1:0]     status;
  logic                    writeback_valid;
  logic [FILE_ID_BITS-1:0] writeback_file_id;
  logic [OFFSET_BITS-1:0]  writeback_offset;

  // Shadow copy of the directory, advanced once per accepted request.
  logic                    dir_valid  [FRAMES];
  logic                    dir_dirty  [FRAMES];
  logic                    dir_pinned [FRAMES];
  logic [FILE_ID_BITS-1:0] dir_file   [FRAMES];
  logic [OFFSET_BITS-1:0]  dir_block  [FRAMES];
  logic [STAMP_BITS-1:0]   dir_stamp  [FRAMES];
  logic [STAMP_BITS-1:0]   access_tick;

  reply_t        pending_replies[$];
  directed_row_t directed_rows[$];

  int mismatches;
  int results_seen;
  int hit_count;
  int fill_count;
  int writeback_count;
  int full_count;
  int done_count;

  buffer_frame_lru_directory DUT (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .operation         (operation),
    .file_id           (file_id),
    .block_offset      (block_offset),
    .frame             (frame),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .frame_out         (frame_out),
    .status            (status),
    .writeback_valid   (writeback_valid),
    .writeback_file_id (writeback_file_id),
    .writeback_offset  (writeback_offset)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic reply_t predict_directory(input request_t req);
    reply_t r;
    int     hit;
    int     slot;
    r.frame    = '0;
    r.status   = STS_DONE;
    r.wb_valid = 1'b0;
    r.wb_file  = '0;
    r.wb_off   = '0;
    hit        = -1;
    slot       = -1;
    case (req.op)
      OP_LOOKUP: begin
        for (int i = 0; i < FRAMES; i++)
          if (hit < 0 && dir_valid[i] && dir_file[i] == req.fid && dir_block[i] == req.off)
            hit = i;
        if (hit >= 0) begin
          access_tick    = access_tick + 1'b1;
          dir_stamp[hit] = access_tick;
          r.frame        = FRAME_W'(hit);
          r.status       = STS_HIT;
        end else begin
          for (int i = 0; i < FRAMES; i++)
            if (slot < 0 && !dir_valid[i])
              slot = i;
          // With no free frame, the oldest unpinned one goes; a strict compare keeps
          // the lowest index on equal stamps.
          if (slot < 0) begin
            for (int i = 0; i < FRAMES; i++)
              if (!dir_pinned[i] && (slot < 0 || dir_stamp[i] < dir_stamp[slot]))
                slot = i;
            if (slot >= 0 && dir_dirty[slot]) begin
              r.wb_valid = 1'b1;
              r.wb_file  = dir_file[slot];
              r.wb_off   = dir_block[slot];
            end
          end
          if (slot < 0) begin
            r.status = STS_FULL;
          end else begin
            dir_valid[slot]  = 1'b1;
            dir_dirty[slot]  = 1'b0;
            dir_pinned[slot] = 1'b0;
            dir_file[slot]   = req.fid;
            dir_block[slot]  = req.off;
            access_tick      = access_tick + 1'b1;
            dir_stamp[slot]  = access_tick;
            r.frame          = FRAME_W'(slot);
            r.status         = STS_MISS;
          end
        end
      end
      OP_DIRTY: dir_dirty[req.fr] = 1'b1;
      OP_PIN:   dir_pinned[req.fr] = 1'b1;
      default: begin
        for (int i = 0; i < FRAMES; i++)
          if (dir_valid[i] && dir_file[i] == req.fid) begin
            dir_valid[i]  = 1'b0;
            dir_dirty[i]  = 1'b0;
            dir_pinned[i] = 1'b0;
          end
      end
    endcase
    return r;
  endfunction

  task automatic add_row(input op_t op, input logic [FILE_ID_BITS-1:0] fid,
                         input logic [OFFSET_BITS-1:0] off, input logic [FRAME_W-1:0] fr,
                         input bit typed, input logic [FRAME_W-1:0] efr, input status_t est,
                         input logic ewb, input logic [FILE_ID_BITS-1:0] ewf,
                         input logic [OFFSET_BITS-1:0] ewo);
    directed_row_t row;
    row.req.op        = op;
    row.req.fid       = fid;
    row.req.off       = off;
    row.req.fr        = fr;
    row.typed         = typed;
    row.want.frame    = efr;
    row.want.status   = est;
    row.want.wb_valid = ewb;
    row.want.wb_file  = ewf;
    row.want.wb_off   = ewo;
    directed_rows.push_back(row);
  endtask

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic offer_request(input request_t req, input int idx, input bit typed,
                               input reply_t want);
    reply_t predicted;
    int     gap_pct;
    case ((idx / 150) % 3)
      0:       gap_pct = 15;
      1:       gap_pct = 0;
      default: gap_pct = 40;
    endcase
    if (idx >= TOTAL_REQUESTS - QUIET_TAIL)
      gap_pct = 0;
    if ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_valid     <= 1'b1;
    operation    <= req.op;
    file_id      <= req.fid;
    block_offset <= req.off;
    frame        <= req.fr;
    do @(posedge clk); while (in_stall);
    predicted = predict_directory(req);
    pending_replies.push_back(typed ? want : predicted);
    @(negedge clk);
  endtask

  initial begin : receiver
    int stall_left;
    int holds_done;
    int stall_pct;
    out_stall  = 1'b0;
    stall_left = 0;
    holds_done = 0;
    forever begin
      @(negedge clk);
      case ((results_seen / 200) % 3)
        0:       stall_pct = 10;
        1:       stall_pct = 35;
        default: stall_pct = 0;
      endcase
      // Two long hold-offs, so that the block backs up and stalls its input.
      if (stall_left == 0 && ((holds_done == 0 && results_seen >= 300) ||
                              (holds_done == 1 && results_seen >= 1100))) begin
        stall_left = LONG_HOLD;
        holds_done++;
      end else if (stall_left == 0 && results_seen < TOTAL_REQUESTS - QUIET_TAIL &&
                   $urandom_range(0, 99) < stall_pct) begin
        stall_left = $urandom_range(1, 17);
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    reply_t want;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      case (status)
        STS_HIT:  hit_count++;
        STS_MISS: fill_count++;
        STS_FULL: full_count++;
        default:  done_count++;
      endcase
      if (writeback_valid === 1'b1)
        writeback_count++;
      if (pending_replies.size() == 0) begin
        $display("%0t: unexpected result: frame %0d status %0d wb %0b %0h %0h", $time,
                 frame_out, status, writeback_valid, writeback_file_id, writeback_offset);
        mismatches++;
      end else begin
        want = pending_replies.pop_front();
        if (frame_out !== want.frame || status !== want.status ||
            writeback_valid !== want.wb_valid || writeback_file_id !== want.wb_file ||
            writeback_offset !== want.wb_off) begin
          $display("%0t: mismatch: expected frame %0d status %0d wb %0b %0h %0h", $time,
                   want.frame, want.status, want.wb_valid, want.wb_file, want.wb_off);
          $display("%0t:           actual frame %0d status %0d wb %0b %0h %0h", $time,
                   frame_out, status, writeback_valid, writeback_file_id, writeback_offset);
          mismatches++;
        end
      end
    end
  end

  initial begin : stimulus
    request_t                req;
    reply_t                  no_reply;
    int                      pick;
    int                      k;
    int                      random_items;
    logic [FILE_ID_BITS-1:0] file_ids [4];
    logic [FILE_ID_BITS-1:0] pool_file [TAG_POOL];
    logic [OFFSET_BITS-1:0]  pool_off [TAG_POOL];

    mismatches      = 0;
    results_seen    = 0;
    hit_count       = 0;
    fill_count      = 0;
    writeback_count = 0;
    full_count      = 0;
    done_count      = 0;
    rst             = 1'b1;
    in_valid        = 1'b0;
    operation       = OP_LOOKUP;
    file_id         = '0;
    block_offset    = '0;
    frame           = '0;
    for (int i = 0; i < FRAMES; i++) begin
      dir_valid[i]  = 1'b0;
      dir_dirty[i]  = 1'b0;
      dir_pinned[i] = 1'b0;
      dir_file[i]   = '0;
      dir_block[i]  = '0;
      dir_stamp[i]  = '0;
    end
    access_tick       = '0;
    no_reply.frame    = '0;
    no_reply.status   = STS_DONE;
    no_reply.wb_valid = 1'b0;
    no_reply.wb_file  = '0;
    no_reply.wb_off   = '0;

    //       op         file    offset     frame typed frame status    wb  wb file wb offset
    add_row(OP_LOOKUP, 8'h00, 20'h00000, 3'd0, 1, 3'd0, STS_MISS, 0, 8'h00, 20'h00000);
    add_row(OP_LOOKUP, 8'hFF, 20'hFFFFF, 3'd7, 1, 3'd1, STS_MISS, 0, 8'h00, 20'h00000);
    add_row(OP_LOOKUP, 8'h00, 20'h00000, 3'd0, 1, 3'd0, STS_HIT,  0, 8'h00, 20'h00000);
    add_row(OP_DIRTY,  8'h00, 20'h00000, 3'd1, 1, 3'd0, STS_DONE, 0, 8'h00, 20'h00000);
    add_row(OP_PIN,    8'hFF, 20'hFFFFF, 3'd0, 1, 3'd0, STS_DONE, 0, 8'h00, 20'h00000);
    // Marks on free frames are set now and cleared when those frames are filled.
    add_row(OP_DIRTY,  8'h00, 20'h00000, 3'd7, 1, 3'd0, STS_DONE, 0, 8'h00, 20'h00000);
    add_row(OP_PIN,    8'h00, 20'h00000, 3'd6, 1, 3'd0, STS_DONE, 0, 8'h00, 20'h00000);
    for (int i = 1; i <= 6; i++)
      add_row(OP_LOOKUP, 8'(i), 20'(i), 3'd0, 0, 3'd0, STS_DONE, 0, 8'h00, 20'h00000);
    // Pool full: the dirty frame 1 is oldest among the unpinned and is written back.
    add_row(OP_LOOKUP, 8'h07, 20'h12345, 3'd0, 1, 3'd1, STS_MISS, 1, 8'hFF, 20'hFFFFF);
    add_row(OP_LOOKUP, 8'h08, 20'h80000, 3'd5, 0, 3'd0, STS_DONE, 0, 8'h00, 20'h00000);
    for (int i = 1; i < FRAMES; i++)
      add_row(OP_PIN, 8'h00, 20'h00000, 3'(i), 1, 3'd0, STS_DONE, 0, 8'h00, 20'h00000);
    add_row(OP_LOOKUP, 8'h09, 20'h00009, 3'd0, 1, 3'd0, STS_FULL, 0, 8'h00, 20'h00000);
    add_row(OP_DROP,   8'h00, 20'h00000, 3'd0, 1, 3'd0, STS_DONE, 0, 8'h00, 20'h00000);
    add_row(OP_LOOKUP, 8'h55, 20'hAAAAA, 3'd2, 0, 3'd0, STS_DONE, 0, 8'h00, 20'h00000);

    repeat (10) @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      offer_request(directed_rows[i].req, i, directed_rows[i].typed, directed_rows[i].want);
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_replies.size() != 0);

    // A small set of tags over four files keeps hits, evictions and drops frequent.
    foreach (file_ids[i])
      file_ids[i] = FILE_ID_BITS'($urandom);
    for (int i = 0; i < TAG_POOL; i++) begin
      pool_file[i] = file_ids[$urandom_range(0, 3)];
      pool_off[i]  = OFFSET_BITS'($urandom);
    end

    random_items = TOTAL_REQUESTS - directed_rows.size();
    for (int n = 0; n < random_items; n++) begin
      // Halfway through, the sender waits until every transfer has been answered.
      if (n == random_items / 2) begin
        in_valid <= 1'b0;
        do @(negedge clk); while (pending_replies.size() != 0);
      end
      if ($urandom_range(0, 63) == 0) begin
        k            = $urandom_range(0, TAG_POOL - 1);
        pool_file[k] = ($urandom_range(0, 1) == 0) ? file_ids[$urandom_range(0, 3)] :
                                                     FILE_ID_BITS'($urandom);
        pool_off[k]  = OFFSET_BITS'($urandom);
      end
      req.fid = FILE_ID_BITS'($urandom);
      req.off = OFFSET_BITS'($urandom);
      req.fr  = FRAME_W'($urandom);
      pick    = $urandom_range(0, 99);
      if (pick < 62) begin
        req.op = OP_LOOKUP;
        if ($urandom_range(0, 3) != 0) begin
          k       = $urandom_range(0, TAG_POOL - 1);
          req.fid = pool_file[k];
          req.off = pool_off[k];
        end
      end else if (pick < 80) begin
        req.op = OP_DIRTY;
      end else if (pick < 88) begin
        req.op = OP_PIN;
      end else begin
        req.op = OP_DROP;
        if ($urandom_range(0, 3) != 0)
          req.fid = file_ids[$urandom_range(0, 3)];
      end
      offer_request(req, directed_rows.size() + n, 1'b0, no_reply);
    end

    in_valid <= 1'b0;
    do @(negedge clk); while (pending_replies.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("Checked %0d results: %0d hits, %0d fills (%0d with write-back),",
             results_seen, hit_count, fill_count, writeback_count);
    $display("%0d lookups finding every frame pinned, %0d mark, pin and drop requests.",
             full_count, done_count);
    if (mismatches == 0 && pending_replies.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
